// ===== sv/cdte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdte_pkg
// Shared types and constants for the civil date to epoch seconds converter.
// ----------------------------------------------------------------------------
package cdte_pkg;

	// Configuration register indexes
	localparam logic REG_ZONE_MODE   = 1'b0;
	localparam logic REG_ZONE_OFFSET = 1'b1;

	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned SECS_W     = 39;
	localparam int unsigned OFFSET_W   = 11;

	// era = floor(y / 400) as (y * ERA_RECIP) >> ERA_SHIFT, exact for y < 43690
	localparam logic [28:0] ERA_RECIP = 29'd20972;
	localparam int unsigned ERA_SHIFT = 23;

	localparam logic signed [15:0] YEARS_PER_ERA = 16'sd400;
	localparam logic signed [24:0] DAYS_PER_ERA  = 25'sd146097;
	localparam logic signed [24:0] EPOCH_SHIFT   = 25'sd719468;
	localparam logic [18:0]        DAYS_PER_YEAR = 19'd365;
	localparam logic [16:0]        SEC_PER_HOUR  = 17'd3600;
	localparam logic [16:0]        SEC_PER_MIN   = 17'd60;
	localparam logic signed [17:0] SEC_PER_MIN_S = 18'sd60;
	localparam logic signed [43:0] SEC_PER_DAY   = 44'sd86400;

	localparam logic signed [43:0] SECS_MAX = 44'sd274877906943;
	localparam logic signed [43:0] SECS_MIN = -44'sd274877906944;

	localparam logic [4:0] HOUR_LAST = 5'd23;
	localparam logic [5:0] MIN_LAST  = 6'd59;

	// Per-stage load enables from the flow control to the datapath
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic out;
	} cdte_load_t;

	// Days from 1 March to the first of the March-based month: (153*mp + 2) / 5
	function automatic logic [8:0] month_days(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/civil_datetime_to_epoch_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_unit
// Civil date and wall-clock hour/minute to signed seconds since 1970-01-01 UTC,
// with an optional fixed zone offset.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------
//  s_*      | in        | s_tvalid / s_tready    | s_tdata: year, month, day, hour, minute
//  m_*      | out       | m_tvalid / m_tready    | m_tdata: epoch_seconds; m_tuser: status
//  cfg_*    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transaction per cycle while m_tready is high; a result passes the input
// register, three stage registers and the output register, and is held in the
// output register until it is taken on m_*. Each stage
// holds its own valid bit and fills when empty, so bubbles close up while
// m_tready is low. Reset clears the valid bits and both zone registers;
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module civil_datetime_to_epoch_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [13:0] year, [17:14] month, [22:18] day, [27:23] hour, [33:28] minute
	input  logic [cdte_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [38:0] epoch_seconds
	output logic [cdte_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] status
	output logic                                m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [cdte_pkg::OFFSET_W-1:0]       cfg_data
);

	logic                                 zone_mode_q;
	logic signed [cdte_pkg::OFFSET_W-1:0] zone_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_mode_q   <= 1'b0;
			zone_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cdte_pkg::REG_ZONE_MODE:   zone_mode_q   <= cfg_data[0];
				cdte_pkg::REG_ZONE_OFFSET: zone_offset_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// flow control: a stage loads when empty or when its content moves on
	cdte_pkg::cdte_load_t ld;
	logic v1_q, v2_q, v3_q, v4_q, vo_q;

	assign ld.out = !vo_q || m_tready;
	assign ld.s4  = !v4_q || ld.out;
	assign ld.s3  = !v3_q || ld.s4;
	assign ld.s2  = !v2_q || ld.s3;
	assign ld.s1  = !v1_q || ld.s2;

	assign s_tready = ld.s1;
	assign m_tvalid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (ld.s1)  v1_q <= s_tvalid;
			if (ld.s2)  v2_q <= v1_q;
			if (ld.s3)  v3_q <= v2_q;
			if (ld.s4)  v4_q <= v3_q;
			if (ld.out) vo_q <= v4_q;
		end
	end

	logic [cdte_pkg::SECS_W-1:0] epoch_seconds;
	logic                        status;

	cdte_datapath u_datapath (
		.clk           (clk),
		.ld            (ld),
		.year          (s_tdata[13:0]),
		.month         (s_tdata[17:14]),
		.day           (s_tdata[22:18]),
		.hour          (s_tdata[27:23]),
		.minute        (s_tdata[33:28]),
		.zone_mode     (zone_mode_q),
		.zone_offset   (zone_offset_q),
		.epoch_seconds (epoch_seconds),
		.status        (status)
	);

	assign m_tdata = {{(cdte_pkg::OUT_DATA_W - cdte_pkg::SECS_W){1'b0}}, epoch_seconds};
	assign m_tuser = status;

endmodule

// ===== sv/cdte_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdte_datapath
// Input register and four arithmetic stages: era split, era days and time of
// day, day count and zone offset, scaling to seconds with saturation, or zero
// on an invalid hour or minute.
module cdte_datapath (
	input  logic                              clk,
	input  cdte_pkg::cdte_load_t              ld,
	input  logic [13:0]                       year,
	input  logic [3:0]                        month,
	input  logic [4:0]                        day,
	input  logic [4:0]                        hour,
	input  logic [5:0]                        minute,
	input  logic                              zone_mode,
	input  logic signed [cdte_pkg::OFFSET_W-1:0] zone_offset,
	output logic [cdte_pkg::SECS_W-1:0]       epoch_seconds,
	output logic                              status
);

	// input register
	logic [13:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			year_s1   <= year;
			month_s1  <= month;
			day_s1    <= day;
			hour_s1   <= hour;
			minute_s1 <= minute;
		end
	end

	// stage A: March-based year, era, day of year
	logic               early_a;
	logic signed [14:0] y_a;
	logic [28:0]        era_prod_a;
	logic signed [6:0]  era_a;
	logic [3:0]         mp_a;
	logic signed [9:0]  doy_a;
	logic               err_a;

	assign early_a    = (month_s1 <= 4'd2);
	assign y_a        = $signed({1'b0, year_s1} - {14'd0, early_a});
	assign era_prod_a = 29'(y_a[13:0]) * cdte_pkg::ERA_RECIP;
	// only year 0 in Jan/Feb goes negative, which lies in era -1
	assign era_a      = y_a[14] ? -7'sd1
		: $signed({1'b0, era_prod_a[cdte_pkg::ERA_SHIFT +: 6]});
	assign mp_a       = early_a ? month_s1 + 4'd9 : month_s1 - 4'd3;
	assign doy_a      = $signed({1'b0, cdte_pkg::month_days(mp_a)})
		+ $signed({5'd0, day_s1}) - 10'sd1;
	assign err_a      = (hour_s1 > cdte_pkg::HOUR_LAST) || (minute_s1 > cdte_pkg::MIN_LAST);

	logic signed [14:0] y_s2;
	logic signed [6:0]  era_s2;
	logic signed [9:0]  doy_s2;
	logic [4:0]         hour_s2;
	logic [5:0]         minute_s2;
	logic               err_s2;

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			y_s2      <= y_a;
			era_s2    <= era_a;
			doy_s2    <= doy_a;
			hour_s2   <= hour_s1;
			minute_s2 <= minute_s1;
			err_s2    <= err_a;
		end
	end

	// stage B: year of era, days up to the era start, time of day
	logic signed [15:0] era_years_b;
	logic signed [15:0] yoe_full_b;
	logic signed [24:0] era_mul_b;
	logic signed [24:0] era_days_full_b;
	logic [16:0]        tod_b;

	assign era_years_b     = 16'(era_s2) * cdte_pkg::YEARS_PER_ERA;
	assign yoe_full_b      = 16'(y_s2) - era_years_b;
	assign era_mul_b       = 25'(era_s2) * cdte_pkg::DAYS_PER_ERA;
	assign era_days_full_b = era_mul_b - cdte_pkg::EPOCH_SHIFT;
	assign tod_b           = 17'(hour_s2) * cdte_pkg::SEC_PER_HOUR
		+ 17'(minute_s2) * cdte_pkg::SEC_PER_MIN;

	logic [8:0]         yoe_s3;
	logic signed [23:0] era_days_s3;
	logic signed [9:0]  doy_s3;
	logic [16:0]        tod_s3;
	logic               err_s3;

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			yoe_s3      <= yoe_full_b[8:0];
			era_days_s3 <= era_days_full_b[23:0];
			doy_s3      <= doy_s2;
			tod_s3      <= tod_b;
			err_s3      <= err_s2;
		end
	end

	// stage C: day of era, day count, seconds of day less zone offset
	logic [1:0]         cent_c;
	logic [18:0]        doe_u_c;
	logic signed [18:0] doe_c;
	logic signed [23:0] days_c;
	logic signed [17:0] off_sec_c;
	logic signed [18:0] sod_c;

	assign cent_c    = {1'b0, yoe_s3 >= 9'd100} + {1'b0, yoe_s3 >= 9'd200}
		+ {1'b0, yoe_s3 >= 9'd300};
	assign doe_u_c   = 19'(yoe_s3) * cdte_pkg::DAYS_PER_YEAR + 19'(yoe_s3[8:2])
		- 19'(cent_c);
	assign doe_c     = $signed(doe_u_c) + 19'(doy_s3);
	assign days_c    = era_days_s3 + 24'(doe_c);
	assign off_sec_c = zone_mode ? 18'(zone_offset) * cdte_pkg::SEC_PER_MIN_S : 18'sd0;
	assign sod_c     = $signed({2'b00, tod_s3}) - 19'(off_sec_c);

	logic signed [23:0] days_s4;
	logic signed [18:0] sod_s4;
	logic               err_s4;

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			days_s4 <= days_c;
			sod_s4  <= sod_c;
			err_s4  <= err_s3;
		end
	end

	// stage D: scale to seconds and clamp to the 39-bit signed range; zero on error
	logic signed [43:0]               day_sec_d;
	logic signed [43:0]               secs_d;
	logic [cdte_pkg::SECS_W-1:0]      sat_d;

	assign day_sec_d = 44'(days_s4) * cdte_pkg::SEC_PER_DAY;
	assign secs_d    = day_sec_d + 44'(sod_s4);

	always_comb begin
		if (err_s4) begin
			sat_d = '0;
		end else if (secs_d > cdte_pkg::SECS_MAX) begin
			sat_d = cdte_pkg::SECS_MAX[cdte_pkg::SECS_W-1:0];
		end else if (secs_d < cdte_pkg::SECS_MIN) begin
			sat_d = cdte_pkg::SECS_MIN[cdte_pkg::SECS_W-1:0];
		end else begin
			sat_d = secs_d[cdte_pkg::SECS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld.out) begin
			epoch_seconds <= sat_d;
			status        <= err_s4;
		end
	end

endmodule
